### rtl/local_threshold_binarizer_macros.svh
// ----------------------------------------------------------------------------
// local threshold binarizer assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef LOCAL_THRESHOLD_BINARIZER_MACROS_SVH
`define LOCAL_THRESHOLD_BINARIZER_MACROS_SVH

// same-cycle implication
`define LTHB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LTHB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/lthb_pkg.sv
// ----------------------------------------------------------------------------
// lthb_pkg
// shared types and constants of the local threshold binarizer
// ----------------------------------------------------------------------------
package lthb_pkg;

  localparam int SumW   = 24;       // window sum width
  localparam int SqW    = 16;       // window squared width
  localparam int QShift = 21;
  localparam int QOne   = 2097152;  // 1.0 in threshold scaling
  localparam int DevBias = 128;
  localparam logic [7:0] White = 8'd255;
  localparam logic [7:0] Black = 8'd0;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_WINDOW = 2'd2,
    CFG_K      = 2'd3
  } cfg_idx_e;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_DRAIN = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_OUT   = 7'b0100000,
    S_WAIT  = 7'b1000000
  } state_e;

  typedef enum logic [1:0] {
    PH_CUR  = 2'd0,
    PH_LEFT = 2'd1,
    PH_UP   = 2'd2,
    PH_WIN  = 2'd3
  } phase_e;

endpackage

### rtl/local_threshold_binarizer.sv
// ----------------------------------------------------------------------------
// local_threshold_binarizer
// adaptive local threshold binarizer over a pixel store in on-chip memory
// ----------------------------------------------------------------------------
// load: one write, next word taken the cycle after
// query: 3 neighbor reads + one read per window pixel (one memory port, one
//   pixel a cycle), then drain, divide, multiply, output and wait states
// reset clears control state, presets config; pixel store holds no reset
module local_threshold_binarizer #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input word channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               operation_i,
  input  logic [7:0]         col_i,
  input  logic [7:0]         row_i,
  input  logic [7:0]         pixel_value_i,
  // result word channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         binary_value_o,
  output logic signed [12:0] threshold_o,
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [14:0]        cfg_data_i
);

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(Depth);

  // configuration registers
  logic [8:0]  width_q, height_q;
  logic [7:0]  win_q;
  logic [14:0] k_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'd256;
      height_q <= 9'd256;
      win_q    <= 8'd15;
      k_q      <= 15'd3277;
    end else if (cfg_valid_i) begin
      unique case (lthb_pkg::cfg_idx_e'(cfg_index_i))
        lthb_pkg::CFG_WIDTH:  width_q  <= cfg_data_i[8:0];
        lthb_pkg::CFG_HEIGHT: height_q <= cfg_data_i[8:0];
        lthb_pkg::CFG_WINDOW: win_q    <= cfg_data_i[7:0];
        lthb_pkg::CFG_K:      k_q      <= cfg_data_i;
      endcase
    end
  end

  // effective image size: zero acts as one, clipped to the store
  logic [12:0] w_ext, h_ext;
  logic [9:0]  w_eff, h_eff;

  always_comb begin
    w_ext = {4'b0, width_q};
    if (width_q == 9'd0) w_ext = 13'd1;
    else if (w_ext > 13'(MAX_WIDTH)) w_ext = 13'(MAX_WIDTH);
    h_ext = {4'b0, height_q};
    if (height_q == 9'd0) h_ext = 13'd1;
    else if (h_ext > 13'(MAX_HEIGHT)) h_ext = 13'(MAX_HEIGHT);
    w_eff = w_ext[9:0];
    h_eff = h_ext[9:0];
  end

  // window bounds of the incoming query, clipped to the image
  logic [7:0]  win;
  logic [9:0]  half, col10, row10, cplus, rplus;
  logic [9:0]  x0, x1, y0, y1;

  assign win   = (win_q == 8'd0) ? 8'd1 : win_q;
  assign half  = {3'b0, win[7:1]};
  assign col10 = {2'b0, col_i};
  assign row10 = {2'b0, row_i};
  assign cplus = col10 + half;
  assign rplus = row10 + half;
  assign x0    = (col10 > half) ? col10 - half : 10'd0;
  assign y0    = (row10 > half) ? row10 - half : 10'd0;
  assign x1    = (cplus < w_eff - 10'd1) ? cplus : w_eff - 10'd1;
  assign y1    = (rplus < h_eff - 10'd1) ? rplus : h_eff - 10'd1;

  lthb_pkg::state_e state_q, state_d;

  logic in_acc, load_we, query_go;

  assign in_stall_o = (state_q != lthb_pkg::S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign load_we    = in_acc && (operation_i == lthb_pkg::OpLoad)
                   && ({5'b0, col_i} < 13'(MAX_WIDTH))
                   && ({5'b0, row_i} < 13'(MAX_HEIGHT));
  // queries outside the image leave no result and no work
  assign query_go   = in_acc && (operation_i == lthb_pkg::OpQuery)
                   && (col10 < w_eff) && (row10 < h_eff);

  // query context
  logic [9:0]  col_q, row_q, x0_q, x1_q, y1_q, xi_q, yi_q;
  logic [lthb_pkg::SqW-1:0] winsq_q;
  lthb_pkg::phase_e ph_q;

  // read address, one memory read a cycle while sweeping
  logic [9:0]    rd_x, rd_y;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          rd_en;

  always_comb begin
    rd_x = col_q;
    rd_y = row_q;
    case (ph_q)
      lthb_pkg::PH_CUR:  ;
      lthb_pkg::PH_LEFT: rd_x = (col_q == 10'd0) ? 10'd0 : col_q - 10'd1;
      lthb_pkg::PH_UP:   rd_y = (row_q == 10'd0) ? 10'd0 : row_q - 10'd1;
      default: begin
        rd_x = xi_q;
        rd_y = yi_q;
      end
    endcase
  end

  assign rd_en   = (state_q == lthb_pkg::S_READ);
  assign rd_addr = AW'(32'(rd_y) * 32'(MAX_WIDTH) + 32'(rd_x));
  assign wr_addr = AW'(32'(row_i) * 32'(MAX_WIDTH) + 32'(col_i));

  // pixel store, one write and one registered read port
  logic [7:0] mem_q [Depth];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (load_we) mem_q[wr_addr] <= pixel_value_i;
    if (rd_en)   rd_data_q <= mem_q[rd_addr];
  end

  // tag travels with each read to steer the returning pixel
  logic             tag_vld_q;
  lthb_pkg::phase_e tag_ph_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_vld_q <= 1'b0;
      tag_ph_q  <= lthb_pkg::PH_CUR;
    end else begin
      tag_vld_q <= rd_en;
      tag_ph_q  <= ph_q;
    end
  end

  // gathered pixels and window sum
  logic [7:0]               cur_q, left_q, up_q;
  logic [lthb_pkg::SumW-1:0] sum_q, sum_d;

  always_comb begin
    sum_d = sum_q;
    if (tag_vld_q && tag_ph_q == lthb_pkg::PH_WIN) begin
      sum_d = sum_q + lthb_pkg::SumW'(rd_data_q);
    end
  end

  // divider for mean = sum / window squared
  logic                      div_done;
  logic [lthb_pkg::SumW-1:0] quot;

  lthb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == lthb_pkg::S_DRAIN),
    .dividend_i (sum_d),
    .divisor_i  (winsq_q),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // threshold arithmetic
  logic [9:0]         mean_q;
  logic signed [10:0] dev_m;
  logic signed [26:0] kprod_q;
  logic signed [37:0] prod_q, thr_full;
  logic signed [12:0] thr_sat;
  logic [7:0]         bin;

  assign dev_m = $signed({3'b0, cur_q}) - $signed({3'b0, left_q})
               - $signed({3'b0, up_q}) - 11'sd128;

  // truncate toward zero on the scaling shift
  assign thr_full = (prod_q + (prod_q[37] ? 38'(lthb_pkg::QOne - 1) : 38'sd0))
                    >>> lthb_pkg::QShift;

  always_comb begin
    if (thr_full > 38'sd4095)       thr_sat = 13'sd4095;
    else if (thr_full < -38'sd4096) thr_sat = -13'sd4096;
    else                            thr_sat = thr_full[12:0];
  end

  assign bin = ($signed({30'b0, cur_q}) < thr_full) ? lthb_pkg::Black : lthb_pkg::White;

  // output register
  logic               out_valid_q;
  logic [7:0]         out_bin_q;
  logic signed [12:0] out_thr_q;
  logic               out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lthb_pkg::S_IDLE:  if (query_go) state_d = lthb_pkg::S_READ;
      lthb_pkg::S_READ:  if (ph_q == lthb_pkg::PH_WIN && xi_q == x1_q && yi_q == y1_q)
                           state_d = lthb_pkg::S_DRAIN;
      lthb_pkg::S_DRAIN: state_d = lthb_pkg::S_DIV;
      lthb_pkg::S_DIV:   if (div_done) state_d = lthb_pkg::S_MUL;
      lthb_pkg::S_MUL:   state_d = lthb_pkg::S_OUT;
      lthb_pkg::S_OUT:   state_d = lthb_pkg::S_WAIT;
      lthb_pkg::S_WAIT:  if (out_free) state_d = lthb_pkg::S_IDLE;
      default:           state_d = lthb_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lthb_pkg::S_IDLE;
      ph_q        <= lthb_pkg::PH_CUR;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (query_go) begin
        ph_q <= lthb_pkg::PH_CUR;
      end else if (rd_en && ph_q != lthb_pkg::PH_WIN) begin
        ph_q <= lthb_pkg::phase_e'(ph_q + 2'd1);
      end
      if (state_q == lthb_pkg::S_WAIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (query_go) begin
      col_q   <= col10;
      row_q   <= row10;
      x0_q    <= x0;
      x1_q    <= x1;
      y1_q    <= y1;
      xi_q    <= x0;
      yi_q    <= y0;
      winsq_q <= win * win;
      sum_q   <= '0;
    end else begin
      sum_q <= sum_d;
      // raster sweep over the window
      if (rd_en && ph_q == lthb_pkg::PH_WIN) begin
        if (xi_q == x1_q) begin
          xi_q <= x0_q;
          yi_q <= yi_q + 10'd1;
        end else begin
          xi_q <= xi_q + 10'd1;
        end
      end
    end
    if (tag_vld_q) begin
      case (tag_ph_q)
        lthb_pkg::PH_CUR:  cur_q  <= rd_data_q;
        lthb_pkg::PH_LEFT: left_q <= rd_data_q;
        lthb_pkg::PH_UP:   up_q   <= rd_data_q;
        default: ;
      endcase
    end
    if (state_q == lthb_pkg::S_DIV) begin
      kprod_q <= $signed({1'b0, k_q}) * dev_m + 27'(lthb_pkg::QOne);
      if (div_done) mean_q <= quot[9:0];
    end
    if (state_q == lthb_pkg::S_MUL) prod_q <= $signed({1'b0, mean_q}) * kprod_q;
    // payload only moves when the previous word has left
    if (state_q == lthb_pkg::S_WAIT && out_free) begin
      out_bin_q <= bin;
      out_thr_q <= thr_sat;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign binary_value_o = out_bin_q;
  assign threshold_o    = out_thr_q;

endmodule

### rtl/lthb_div.sv
// ----------------------------------------------------------------------------
// lthb_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lthb_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [lthb_pkg::SumW-1:0]    dividend_i,
  input  logic [lthb_pkg::SqW-1:0]     divisor_i,
  output logic                         done_o,
  output logic [lthb_pkg::SumW-1:0]    quotient_o
);

  localparam int CntW = $clog2(lthb_pkg::SumW);

  logic                       busy_q, done_q;
  logic [CntW-1:0]            cnt_q;
  logic [lthb_pkg::SqW-1:0]   rem_q, dvs_q;
  logic [lthb_pkg::SumW-1:0]  dq_q;
  logic [lthb_pkg::SqW:0]     trial;
  logic                       fits;

  assign trial = {rem_q, dq_q[lthb_pkg::SumW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CntW'(lthb_pkg::SumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      dq_q  <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? lthb_pkg::SqW'(trial - {1'b0, dvs_q}) : trial[lthb_pkg::SqW-1:0];
      dq_q  <= {dq_q[lthb_pkg::SumW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

### rtl/lthb_checker.sv
// ----------------------------------------------------------------------------
// lthb_checker
// port-level assertions on the local threshold binarizer
// ----------------------------------------------------------------------------
`include "local_threshold_binarizer_macros.svh"

module lthb_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               operation_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [7:0]         binary_value_o,
  input logic signed [12:0] threshold_o
);

  `LTHB_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(binary_value_o) && $stable(threshold_o), "stalled result word changed")
  `LTHB_ASSERT_IMP(a_bin_code, out_valid_o, binary_value_o == lthb_pkg::Black || binary_value_o == lthb_pkg::White, "binary value not black or white")
  `LTHB_ASSERT_IMP(a_black_thr, out_valid_o && binary_value_o == lthb_pkg::Black, !threshold_o[12] && threshold_o != 13'sd0, "black pixel with non-positive threshold")
  `LTHB_ASSERT_NXT(a_load_quiet, in_valid_i && !in_stall_o && operation_i == lthb_pkg::OpLoad && !out_valid_o, !out_valid_o, "load word produced a result")

endmodule

bind local_threshold_binarizer lthb_checker u_lthb_checker (.*);
